>>> rtl/pngmeta_pkg.sv
`default_nettype none

package pngmeta_pkg;

    // Parser phase within the file
    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_DONE = 3'd5
    } t_phase;

    // What the current chunk is being parsed as
    typedef enum logic [1:0] {
        CL_OTHER = 2'd0,
        CL_EXIF  = 2'd1,
        CL_XMP   = 2'd2
    } t_class;

    // Result word kinds
    typedef enum logic [1:0] {
        EV_BYTE     = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_ABANDON  = 2'd2
    } t_event;

    // Blob selector codes
    localparam logic BLOB_EXIF = 1'b0;
    localparam logic BLOB_XMP  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic       blob_select;
        logic [7:0] out_byte;
        t_event     event_res;
    } t_out_word;

    // Chunk types, big-endian ASCII
    localparam logic [31:0] TYPE_EXIF = 32'h6558_4966;
    localparam logic [31:0] TYPE_ITXT = 32'h6954_5874;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    // Byte counters within the fixed-size fields
    localparam logic [2:0] SIG_LAST   = 3'd7;
    localparam logic [2:0] FIELD_LAST = 3'd3;

    // iTXt header layout: keyword with its NUL, compression flag, method byte
    localparam logic [4:0]  KEY_BYTES    = 5'd18;
    localparam logic [4:0]  HDR_END      = 5'd20;
    localparam logic [31:0] ITXT_MIN_LEN = 32'd20;
    localparam logic [1:0]  NUL_FIELDS   = 2'd2;

    // Expected keyword byte, including its terminating NUL
    function automatic logic [7:0] xmp_key_byte(input logic [4:0] idx);
        logic [7:0] kb;
        unique case (idx)
            5'd0:    kb = 8'h58;
            5'd1:    kb = 8'h4D;
            5'd2:    kb = 8'h4C;
            5'd3:    kb = 8'h3A;
            5'd4:    kb = 8'h63;
            5'd5:    kb = 8'h6F;
            5'd6:    kb = 8'h6D;
            5'd7:    kb = 8'h2E;
            5'd8:    kb = 8'h61;
            5'd9:    kb = 8'h64;
            5'd10:   kb = 8'h6F;
            5'd11:   kb = 8'h62;
            5'd12:   kb = 8'h65;
            5'd13:   kb = 8'h2E;
            5'd14:   kb = 8'h78;
            5'd15:   kb = 8'h6D;
            5'd16:   kb = 8'h70;
            default: kb = 8'h00;
        endcase
        return kb;
    endfunction

endpackage

`default_nettype wire

>>> rtl/png_metadata_chunk_extractor_unit.sv
`default_nettype none

// PNG metadata extractor: walks the chunks of a PNG file fed one byte per word
// and pulls out the EXIF payload and the XMP packet of an iTXt chunk.
// Input channel: i_in_valid / o_in_ready carry i_in_word (data byte plus a flag
// on the final byte of the file). Output channel: o_out_valid / i_out_ready
// carry o_out_word (blob select, payload byte, event kind).
// Each input word gives zero or one result word: payload bytes, one complete
// event after the last CRC byte of a blob's chunk, or an abandoned event when
// the file ends while a blob with bytes already sent is still open.
// A result is presented in the cycle after its input word is accepted.
// Throughput is one byte per cycle while results are taken, set by the single
// result register; the per-byte work is compares and a 32-bit down-count.
// A stalled receiver holds the result register, and o_in_ready then drops
// until the result is taken; an empty or draining result register lets a new
// byte in every cycle.
// Reset (synchronous, active low) returns the parser to the signature phase
// and empties the result register. The parser also returns to that state
// after the word flagged as last, ready for the next file.
module png_metadata_chunk_extractor_unit
    import pngmeta_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  wire t_in_word i_in_word,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_out_word o_out_word
);

    t_phase      r_phase,    n_phase,    s_phase;
    logic [2:0]  r_sub,      n_sub;
    logic [31:0] r_left,     n_left;
    logic [23:0] r_type,     n_type;
    t_class      r_class,    n_class,    s_class;
    logic [4:0]  r_hidx,     n_hidx;
    logic [1:0]  r_nul,      n_nul;
    logic        r_exif_tkn, n_exif_tkn;
    logic        r_xmp_tkn,  n_xmp_tkn;
    logic        r_any,      n_any,      s_any;

    logic        r_out_valid;
    t_out_word   r_out;

    logic        s_accept;
    logic [7:0]  s_b;
    logic [31:0] s_full_type;
    logic        s_hdr_fail;
    logic        s_emit;
    logic        s_emit_sel;
    logic        s_complete;
    logic        s_abandon;
    logic        s_have;
    t_out_word   s_result;

    assign s_b         = i_in_word.data_byte;
    assign s_full_type = {r_type, s_b};
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign s_accept    = i_in_valid && o_in_ready;

    // Next state: advance the parser by one byte
    always_comb begin
        s_phase    = r_phase;
        n_sub      = r_sub;
        n_left     = r_left;
        n_type     = r_type;
        s_class    = r_class;
        n_hidx     = r_hidx;
        n_nul      = r_nul;
        n_exif_tkn = r_exif_tkn;
        n_xmp_tkn  = r_xmp_tkn;
        s_any      = r_any;
        s_hdr_fail = 1'b0;

        unique case (r_phase)
            PH_SIG: begin
                if (r_sub == SIG_LAST) begin
                    s_phase = PH_LEN;
                    n_sub   = '0;
                end else begin
                    n_sub = r_sub + 3'd1;
                end
            end
            PH_LEN: begin
                n_left = {r_left[23:0], s_b};
                if (r_sub == FIELD_LAST) begin
                    s_phase = PH_TYPE;
                    n_sub   = '0;
                end else begin
                    n_sub = r_sub + 3'd1;
                end
            end
            PH_TYPE: begin
                n_type = {r_type[15:0], s_b};
                if (r_sub != FIELD_LAST) begin
                    n_sub = r_sub + 3'd1;
                end else begin
                    n_sub   = '0;
                    n_hidx  = '0;
                    n_nul   = '0;
                    s_any   = 1'b0;
                    s_class = CL_OTHER;
                    if (s_full_type == TYPE_IEND) begin
                        s_phase = PH_DONE;
                    end else begin
                        if (s_full_type == TYPE_EXIF && !r_exif_tkn) begin
                            s_class = CL_EXIF;
                        end else if (s_full_type == TYPE_ITXT && !r_xmp_tkn &&
                                     r_left > ITXT_MIN_LEN) begin
                            s_class = CL_XMP;
                        end
                        s_phase = (r_left != '0) ? PH_DATA : PH_CRC;
                    end
                end
            end
            PH_DATA: begin
                if (r_class == CL_EXIF) begin
                    s_any = 1'b1;
                end else if (r_class == CL_XMP) begin
                    // check keyword, NUL and compression flag, then skip fields
                    if (r_hidx < KEY_BYTES) begin
                        s_hdr_fail = (s_b != xmp_key_byte(r_hidx));
                        n_hidx     = r_hidx + 5'd1;
                    end else if (r_hidx == KEY_BYTES) begin
                        s_hdr_fail = (s_b != 8'h00);
                        n_hidx     = r_hidx + 5'd1;
                    end else if (r_hidx < HDR_END) begin
                        n_hidx = r_hidx + 5'd1;
                    end else if (r_nul != NUL_FIELDS) begin
                        if (s_b == 8'h00) begin
                            n_nul = r_nul + 2'd1;
                        end
                    end else begin
                        s_any = 1'b1;
                    end
                    if (s_hdr_fail) begin
                        s_class = CL_OTHER;
                    end
                end
                n_left = r_left - 32'd1;
                if (r_left == 32'd1) begin
                    s_phase = PH_CRC;
                    n_sub   = '0;
                end
            end
            PH_CRC: begin
                if (r_sub != FIELD_LAST) begin
                    n_sub = r_sub + 3'd1;
                end else begin
                    if (r_class != CL_OTHER && r_any) begin
                        if (r_class == CL_XMP) begin
                            n_xmp_tkn = 1'b1;
                        end else begin
                            n_exif_tkn = 1'b1;
                        end
                    end
                    s_class = CL_OTHER;
                    s_any   = 1'b0;
                    s_phase = PH_LEN;
                    n_sub   = '0;
                end
            end
            default: begin
            end
        endcase

        n_phase = s_phase;
        n_class = s_class;
        n_any   = s_any;

        // Return to reset after the final byte of the file
        if (i_in_word.last_byte) begin
            n_phase    = PH_SIG;
            n_sub      = '0;
            n_left     = '0;
            n_type     = '0;
            n_class    = CL_OTHER;
            n_hidx     = '0;
            n_nul      = '0;
            n_exif_tkn = 1'b0;
            n_xmp_tkn  = 1'b0;
            n_any      = 1'b0;
        end
    end

    // Outputs: build the result word for this byte
    always_comb begin
        s_emit     = 1'b0;
        s_emit_sel = BLOB_EXIF;
        s_complete = 1'b0;

        if (r_phase == PH_DATA) begin
            if (r_class == CL_EXIF) begin
                s_emit = 1'b1;
            end else if (r_class == CL_XMP && r_hidx == HDR_END && r_nul == NUL_FIELDS) begin
                s_emit     = 1'b1;
                s_emit_sel = BLOB_XMP;
            end
        end

        if (r_phase == PH_CRC && r_sub == FIELD_LAST && r_class != CL_OTHER && r_any) begin
            s_complete = 1'b1;
        end

        s_abandon = i_in_word.last_byte && !s_complete && s_class != CL_OTHER && s_any &&
                    (s_phase == PH_DATA || s_phase == PH_CRC);

        s_have = s_emit || s_complete || s_abandon;

        // drop a payload byte in favour of the abandoned event
        priority if (s_abandon) begin
            s_result.blob_select = (s_class == CL_XMP) ? BLOB_XMP : BLOB_EXIF;
            s_result.out_byte    = 8'h00;
            s_result.event_res   = EV_ABANDON;
        end else if (s_complete) begin
            s_result.blob_select = (r_class == CL_XMP) ? BLOB_XMP : BLOB_EXIF;
            s_result.out_byte    = 8'h00;
            s_result.event_res   = EV_COMPLETE;
        end else begin
            s_result.blob_select = s_emit_sel;
            s_result.out_byte    = s_b;
            s_result.event_res   = EV_BYTE;
        end
    end

    // Hold parser state; advance it on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SIG;
            r_sub      <= '0;
            r_class    <= CL_OTHER;
            r_hidx     <= '0;
            r_nul      <= '0;
            r_exif_tkn <= 1'b0;
            r_xmp_tkn  <= 1'b0;
            r_any      <= 1'b0;
        end else if (s_accept) begin
            r_phase    <= n_phase;
            r_sub      <= n_sub;
            r_class    <= n_class;
            r_hidx     <= n_hidx;
            r_nul      <= n_nul;
            r_exif_tkn <= n_exif_tkn;
            r_xmp_tkn  <= n_xmp_tkn;
            r_any      <= n_any;
        end
    end

    // Length and type shift registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_left <= n_left;
            r_type <= n_type;
        end
    end

    // Result register: load when empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= s_accept && s_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && s_accept && s_have) begin
            r_out <= s_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire
